### design/lfsa_pkg.sv
// Shared constants, types and handshake structs for the lowest free slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lfsa_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ID_W   = 20;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 6;

    localparam int IN_TDATA_W  = ((ID_W + 2 * TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // capture the request beat and reset the scan
        logic scan_step;  // read one entry and check the one read before
        logic commit;     // grant, write the release time, load the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // the last entry is checked in this cycle
        logic out_free;   // the result register can take a new result
    } t_sts;

endpackage

`default_nettype wire

### design/lfsa_ctrl.sv
// Controller state machine of the allocator: sequences capture, scan and commit.
// Depends on lfsa_pkg for the state type and the command and status structs.
`default_nettype none

module lfsa_ctrl import lfsa_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_s_axis_tvalid,
    output logic o_s_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.start     = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the finished grant until the result register is free.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !i_sts.scan_last) |=> (r_state == S_SCAN))
        else $error("scan left before the last entry was checked");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while the result register is occupied");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_SCAN))
        else $error("accepted request did not enter the scan");

endmodule

`default_nettype wire

### design/lfsa_datapath.sv
// Datapath of the allocator: release-time memory, busy bits, scan counter,
// lowest-free search, target register and result register. Depends on lfsa_pkg.
`default_nettype none

module lfsa_datapath import lfsa_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  wire  [IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  wire                      i_cfg_wr_en,
    input  wire  [ID_W-1:0]          i_cfg_wr_data,
    output logic                     o_m_axis_tvalid,
    input  wire                      i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic [OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    logic [TIME_W-1:0] r_mem [SLOTS];
    logic [TIME_W-1:0] r_rd_data;

    logic [SLOTS-1:0]  r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_found;
    logic [IDX_W-1:0]  r_grant;
    logic [ID_W-1:0]   r_target;

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_arrival;
    logic [TIME_W-1:0] r_release;

    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_hit;
    logic              r_out_full;

    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  eval_idx;
    logic              eval;
    logic              expired;
    logic              slot_free;

    // The entry read last cycle is checked now, one behind the read address.
    assign cnt_m1    = r_cnt - CNT_W'(1);
    assign eval_idx  = cnt_m1[IDX_W-1:0];
    assign eval      = i_cmd.scan_step && (r_cnt != '0);
    assign expired   = r_busy[eval_idx] && (r_rd_data <= r_arrival);
    assign slot_free = !r_busy[eval_idx] || expired;

    assign o_sts.scan_last = (r_cnt == CNT_W'(SLOTS));
    assign o_sts.out_free  = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_slot);
    assign o_m_axis_tuser  = {r_out_full, r_out_hit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && (r_cnt < CNT_W'(SLOTS))) begin
            r_rd_data <= r_mem[r_cnt[IDX_W-1:0]];
        end
        if (i_cmd.commit && r_found) begin
            r_mem[r_grant] <= r_release;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (i_cmd.start) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step && !o_sts.scan_last) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (eval) begin
                if (expired) begin
                    r_busy[eval_idx] <= 1'b0;
                end
                if (!r_found && slot_free) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (r_found) begin
                    r_busy[r_grant] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_id      <= i_s_axis_tdata[ID_W-1:0];
            r_arrival <= i_s_axis_tdata[ID_W+TIME_W-1:ID_W];
            r_release <= i_s_axis_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];
        end
        if (eval && !r_found && slot_free) begin
            r_grant <= eval_idx;
        end
        if (i_cmd.commit) begin
            r_out_slot <= r_found ? SLOT_W'(r_grant) : '0;
            r_out_hit  <= (r_id == r_target);
            r_out_full <= !r_found;
        end
    end

    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found) |=> r_busy[$past(r_grant)])
        else $error("granted slot not marked busy");

    a_full_means_all_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_found) |-> (&r_busy))
        else $error("table reported full while a slot is free");

    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_full) |-> (r_out_slot == '0))
        else $error("full result carries a nonzero slot");

endmodule

`default_nettype wire

### design/lowest_free_slot_allocator.sv
// An accepted request beat is scanned over all slots and then committed to the result register.
// The scan reads one release-time memory entry per cycle over all slots and
// checks it in the following cycle; the grant is then committed once the result register is free.
// The input is ready only in the idle state, so a new request is taken only after the last one is committed.
// Reset (synchronous, active low) frees every slot, clears the target id
// and empties the result register; the release-time memory is not cleared.
// Top level of the lowest free slot allocator; joins lfsa_ctrl and lfsa_datapath.
// Depends on lfsa_pkg.
`default_nettype none

module lowest_free_slot_allocator import lfsa_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // request_id [19:0], arrival_time [51:20], release_time [83:52], zero fill above
    input  wire  [IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    // slot_index [5:0], zero fill above
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // target_hit [0], table_full [1]
    output logic [OUT_TUSER_W-1:0]  o_m_axis_tuser,
    input  wire                     i_cfg_wr_en,
    input  wire  [ID_W-1:0]         i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    lfsa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    lfsa_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

### dv/lowest_free_slot_allocator_test.sv
// Self-checking testbench for lowest_free_slot_allocator: drives request beats, predicts
// every grant with a behavioral slot table and compares each result beat field by field.
// Depends on lfsa_pkg and the RTL of the allocator only.

module lowest_free_slot_allocator_test;
    import lfsa_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 600;

    typedef struct packed {
        logic [ID_W-1:0]   request_id;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] release_time;
    } t_request;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              target_hit;
        logic              table_full;
    } t_grant;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // request_id [19:0], arrival_time [51:20], release_time [83:52], zero fill above
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // slot_index [5:0], zero fill above
    logic [OUT_TDATA_W-1:0] m_tdata;
    // target_hit [0], table_full [1]
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [ID_W-1:0]        cfg_wr_data = '0;

    t_request pending_requests[$];
    t_grant   expected_grants[$];
    logic     request_taken = 1'b0;

    // Behavioral copy of the slot table and the target register.
    logic              slot_taken [SLOTS];
    logic [TIME_W-1:0] slot_expiry [SLOTS];
    logic [ID_W-1:0]   target_model;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned holdoff_asked = 0;
    int unsigned holdoff_served = 0;
    int unsigned holdoff_left = 0;

    int unsigned requests_queued = 0;
    int unsigned requests_accepted = 0;
    int unsigned grants_checked = 0;
    int unsigned full_results = 0;
    int unsigned target_results = 0;
    int unsigned target_writes = 0;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;

    logic [ID_W-1:0]   target_setting = '0;
    logic [TIME_W-1:0] traffic_time = '0;

    lowest_free_slot_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // Frees every expired slot, then grants the lowest free one.
    function automatic t_grant allocate_slot(t_request req);
        t_grant g;
        int     pick;
        pick = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_taken[i] && slot_expiry[i] <= req.arrival_time)
                slot_taken[i] = 1'b0;
            if (pick < 0 && !slot_taken[i])
                pick = i;
        end
        g.target_hit = (req.request_id == target_model);
        g.table_full = (pick < 0);
        g.slot_index = '0;
        if (pick >= 0) begin
            slot_taken[pick] = 1'b1;
            slot_expiry[pick] = req.release_time;
            g.slot_index = SLOT_W'(pick);
        end
        return g;
    endfunction

    // Request driver: a beat stays offered until it is taken.
    always @(negedge clk) begin
        t_request nxt;
        if (rst_n && (!s_tvalid || request_taken)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= IN_TDATA_W'({nxt.release_time, nxt.arrival_time, nxt.request_id});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls and long hold-offs on request.
    always @(negedge clk) begin
        if (holdoff_left > 0) begin
            m_tready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_asked != holdoff_served) begin
            m_tready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_served <= holdoff_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge clk) begin
        t_request req;
        t_grant   want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
            target_model = '0;
            request_taken <= 1'b0;
        end else begin
            if (cfg_wr_en)
                target_model = cfg_wr_data;
            request_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                req.request_id = s_tdata[ID_W-1:0];
                req.arrival_time = s_tdata[ID_W +: TIME_W];
                req.release_time = s_tdata[ID_W + TIME_W +: TIME_W];
                expected_grants.insert(expected_grants.size(), allocate_slot(req));
                requests_accepted++;
            end
            if (m_tvalid && m_tready) begin
                grants_checked++;
                if (expected_grants.size() == 0) begin
                    $error("result beat with no request pending: slot_index %0d, tuser %b",
                           m_tdata[SLOT_W-1:0], m_tuser);
                    error_count++;
                end else begin
                    want = expected_grants.pop_front();
                    if (want.table_full) full_results++;
                    if (want.target_hit) target_results++;
                    if (m_tdata[SLOT_W-1:0] !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, m_tdata[SLOT_W-1:0]);
                        error_count++;
                    end
                    if (m_tuser[0] !== want.target_hit) begin
                        $error("target_hit: expected %0d, got %0d", want.target_hit, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d", want.table_full, m_tuser[1]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_request(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arrival,
                                 input logic [TIME_W-1:0] release_at);
        t_request req;
        req.request_id = id;
        req.arrival_time = arrival;
        req.release_time = release_at;
        pending_requests.insert(pending_requests.size(), req);
        requests_queued++;
    endtask

    // Waits until every queued request has produced its result, then lets the block settle.
    task automatic wait_idle();
        while (grants_checked < requests_queued) @(negedge clk);
        repeat (SLOTS + 8) @(negedge clk);
    endtask

    task automatic write_target(input logic [ID_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        target_setting = value;
        target_writes++;
        @(negedge clk);
    endtask

    // One burst of requests. Most bursts are well-formed with rising arrival times and
    // durations picked to fill the table, to keep it half busy, or to churn the low slots.
    task automatic queue_traffic();
        int unsigned       kind;
        int unsigned       count;
        int unsigned       step_max;
        int unsigned       dur_lo;
        int unsigned       dur_hi;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] release_at;
        @(posedge clk);
        kind = $urandom_range(9);
        count = $urandom_range(10, 40);
        step_max = 2;
        dur_lo = 150;
        dur_hi = 4000;
        if ($urandom_range(3) == 0) traffic_time = $urandom();
        case (kind)
            0, 1, 2: count = $urandom_range(70, 100);
            3, 4: begin
                step_max = 4;
                dur_lo = 50;
                dur_hi = 300;
            end
            5, 6: begin
                step_max = 30;
                dur_lo = 0;
                dur_hi = 80;
            end
            7: begin
                traffic_time = 32'hFFFF_FFFF - $urandom_range(0, 300);
                dur_lo = 0;
                dur_hi = 600;
            end
            default: ;
        endcase
        for (int n = 0; n < count; n++) begin
            if (traffic_time > 32'hFFFF_FFFF - step_max)
                traffic_time = 32'hFFFF_FFFF;
            else
                traffic_time = traffic_time + $urandom_range(0, step_max);
            id = ($urandom_range(7) == 0) ? target_setting : ID_W'($urandom());
            arrival = traffic_time;
            if (kind == 9)
                arrival = traffic_time - $urandom_range(0, 100);
            // A release time at or before the arrival is legal and frees on the next beat.
            if ($urandom_range(7) == 0)
                release_at = arrival - $urandom_range(0, 40);
            else
                release_at = arrival + $urandom_range(dur_lo, dur_hi);
            if (kind == 8) begin
                arrival = $urandom();
                release_at = $urandom();
            end
            queue_request(id, arrival, release_at);
        end
    endtask

    initial begin
        int unsigned phase_end;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the target still at its reset value of zero.
        queue_request(20'h00000, 32'h0000_0000, 32'h0000_0000);
        queue_request(20'hFFFFF, 32'h0000_0000, 32'h0000_0064);
        queue_request(20'h00001, 32'h0000_000A, 32'h0000_0005);
        queue_request(20'h00002, 32'h0000_000A, 32'h0000_000A);
        queue_request(20'h00003, 32'h0000_0005, 32'h0000_0032);
        queue_request(20'h00004, 32'h0000_0064, 32'h0000_00C8);
        queue_request(20'h00005, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(20'h00006, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(20'h00007, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(20'h00000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(20'hAAAAA, 32'h0000_0001, 32'h5555_5555);

        write_target(20'hFFFFF);
        @(posedge clk);
        queue_request(20'hFFFFF, 32'hAAAA_AAAA, 32'hAAAA_AAAB);
        queue_request(20'h00000, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_request(20'hFFFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(20'h7FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

        write_target(ID_W'($urandom()));
        @(posedge clk);
        send_idle_pct = 25;
        recv_idle_pct = 81;
        phase_end = requests_queued + 370;
        queue_traffic();
        // The receiver stops for a long stretch while requests keep coming.
        holdoff_asked++;
        while (requests_queued < phase_end) queue_traffic();

        write_target(20'h00000);
        @(posedge clk);
        send_idle_pct = 81;
        recv_idle_pct = 25;
        phase_end = requests_queued + 180;
        while (requests_queued < phase_end) queue_traffic();
        // The sender pauses until the table has answered everything.
        wait_idle();
        phase_end = requests_queued + 180;
        while (requests_queued < phase_end) queue_traffic();

        write_target(ID_W'($urandom()));
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_end = requests_queued + 370;
        queue_traffic();
        holdoff_asked++;
        while (requests_queued < phase_end) queue_traffic();

        wait_idle();
        if (expected_grants.size() != 0) begin
            $error("%0d expected results never arrived", expected_grants.size());
            error_count++;
        end
        $display("Run covered %0d requests and %0d results: %0d with a full table, %0d on the target,",
                 requests_accepted, grants_checked, full_results, target_results);
        $display("under %0d target settings and three idle patterns with two long output stalls.",
                 target_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
